// ===== rtl/telnet_iac_option_filter_macros.svh =====
// Assertion macros used by the telnet IAC option filter checker.
`ifndef TELNET_IAC_OPTION_FILTER_MACROS_SVH
`define TELNET_IAC_OPTION_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TIOF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TIOF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// ===== rtl/tiof_pkg.sv =====
// Types and constants of the telnet IAC option filter.
`default_nettype none

package tiof_pkg;

    // Payload count width, fixed by the payload_length field.
    localparam int CNT_W = 7;

    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_SE   = 8'd240;

    localparam logic [7:0] OPT_COMPRESS2 = 8'd86;
    localparam logic [7:0] OPT_MSDP      = 8'd69;

    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_COMP_ON  = 3'd1;
    localparam logic [2:0] KIND_COMP_OFF = 3'd2;
    localparam logic [2:0] KIND_MSDP_ON  = 3'd3;
    localparam logic [2:0] KIND_MSDP_OFF = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD  = 3'd5;
    localparam logic [2:0] KIND_EMPTY    = 3'd6;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       value;
        logic [CNT_W-1:0] length;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/tiof_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tiof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/tiof_outbuf.sv =====
// Output register with a skid stage for the result channel.
`default_nettype none

module tiof_outbuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    input  wire tiof_pkg::res_t up_data,
    output logic                up_ready,
    output logic                out_valid,
    input  wire logic           out_stall,
    output tiof_pkg::res_t      out_data
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    tiof_pkg::res_t main_reg;
    tiof_pkg::res_t skid_reg;
    logic           main_take;

    assign up_ready  = !skid_valid_reg;
    assign main_take = main_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (up_valid && up_ready)
        begin
            if (!main_valid_reg || main_take)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (main_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            if (!main_valid_reg || main_take)
            begin
                main_reg <= up_data;
            end
            else
            begin
                skid_reg <= up_data;
            end
        end
        else if (main_take && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

`default_nettype wire

// ===== rtl/telnet_iac_option_filter.sv =====
// Telnet receive filter top level: IAC parser, payload RAM and replay sequencer.
//
// One received byte is taken per cycle while in_stall is low, for data, commands and option
// bytes; each gives at most one item. IAC SE closing an MSDP subnegotiation with N stored
// bytes (N from 1 to PAYLOAD_MAX) holds in_stall high until the last byte has been replayed,
// including every cycle that out_stall holds back a replayed byte; the payload RAM's single
// read port replays one byte per cycle unless out_stall holds it back, from its registered
// read data. An empty payload gives one item at once. Results pass through an output
// register with a skid stage, so in_stall is also high while a second result waits behind a
// stalled one, until the receiver takes the first. Payload storage holds no reset contents;
// only bytes written in the current subnegotiation are ever replayed.
`default_nettype none

module telnet_iac_option_filter #(
    parameter int PAYLOAD_MAX = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 in_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [2:0]                      kind,
    output logic [7:0]                      out_value,
    output logic [tiof_pkg::CNT_W-1:0]      payload_length,
    output logic                            last
);

    localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W = tiof_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_IAC,
        ST_NEG,
        ST_SBOPT,
        ST_SBDATA,
        ST_SBIAC
    } state_t;

    state_t             st_reg, st_next;
    logic               neg_act_reg, neg_act_next;   // DO or DONT pending
    logic               neg_off_reg, neg_off_next;   // DONT pending
    logic               msdp_reg, msdp_next;         // subnegotiation is for MSDP
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               rep_active_reg, rep_active_next;
    logic [CNT_W-1:0]   rep_len_reg, rep_len_next;
    logic [CNT_W-1:0]   rep_cnt_reg, rep_cnt_next;
    logic               pend_reg, pend_next;
    logic               pend_last_reg, pend_last_next;

    logic               acc;
    logic               wr_en;
    logic               push_p;
    logic               rep_start;
    logic               can_issue;
    logic               buf_ready;
    logic [7:0]         rd_data;
    tiof_pkg::res_t     res_p;
    tiof_pkg::res_t     res_r;
    tiof_pkg::res_t     up_data;
    tiof_pkg::res_t     out_data;

    assign in_stall = rep_active_reg || !buf_ready;
    assign acc      = in_valid && !in_stall;

    // Parser
    always_comb
    begin
        st_next      = st_reg;
        neg_act_next = neg_act_reg;
        neg_off_next = neg_off_reg;
        msdp_next    = msdp_reg;
        cnt_next     = cnt_reg;
        wr_en        = 1'b0;
        push_p       = 1'b0;
        rep_start    = 1'b0;
        res_p.kind   = tiof_pkg::KIND_DATA;
        res_p.value  = in_byte;
        res_p.length = '0;
        res_p.last   = 1'b1;

        if (acc)
        begin
            unique case (st_reg)
                ST_DATA:
                begin
                    if (in_byte == tiof_pkg::B_IAC)
                    begin
                        st_next = ST_IAC;
                    end
                    else
                    begin
                        push_p = 1'b1;
                    end
                end
                ST_IAC:
                begin
                    if (in_byte == tiof_pkg::B_IAC)
                    begin
                        push_p  = 1'b1;
                        st_next = ST_DATA;
                    end
                    else if (in_byte == tiof_pkg::B_DO || in_byte == tiof_pkg::B_DONT ||
                             in_byte == tiof_pkg::B_WILL || in_byte == tiof_pkg::B_WONT)
                    begin
                        neg_act_next = (in_byte == tiof_pkg::B_DO) ||
                                       (in_byte == tiof_pkg::B_DONT);
                        neg_off_next = (in_byte == tiof_pkg::B_DONT);
                        st_next      = ST_NEG;
                    end
                    else if (in_byte == tiof_pkg::B_SB)
                    begin
                        msdp_next = 1'b0;
                        cnt_next  = '0;
                        st_next   = ST_SBOPT;
                    end
                    else
                    begin
                        st_next = ST_DATA;
                    end
                end
                ST_NEG:
                begin
                    res_p.value = '0;
                    if (neg_act_reg && in_byte == tiof_pkg::OPT_COMPRESS2)
                    begin
                        push_p     = 1'b1;
                        res_p.kind = neg_off_reg ? tiof_pkg::KIND_COMP_OFF
                                                 : tiof_pkg::KIND_COMP_ON;
                    end
                    else if (neg_act_reg && in_byte == tiof_pkg::OPT_MSDP)
                    begin
                        push_p     = 1'b1;
                        res_p.kind = neg_off_reg ? tiof_pkg::KIND_MSDP_OFF
                                                 : tiof_pkg::KIND_MSDP_ON;
                    end
                    neg_act_next = 1'b0;
                    neg_off_next = 1'b0;
                    st_next      = ST_DATA;
                end
                ST_SBOPT:
                begin
                    msdp_next = (in_byte == tiof_pkg::OPT_MSDP);
                    cnt_next  = '0;
                    st_next   = ST_SBDATA;
                end
                ST_SBDATA:
                begin
                    if (in_byte == tiof_pkg::B_IAC)
                    begin
                        st_next = ST_SBIAC;
                    end
                    else if (msdp_reg && cnt_reg < CNT_W'(PAYLOAD_MAX))
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                ST_SBIAC:
                begin
                    if (in_byte == tiof_pkg::B_SE)
                    begin
                        if (msdp_reg)
                        begin
                            if (cnt_reg == '0)
                            begin
                                push_p      = 1'b1;
                                res_p.kind  = tiof_pkg::KIND_EMPTY;
                                res_p.value = '0;
                            end
                            else
                            begin
                                rep_start = 1'b1;
                            end
                        end
                        msdp_next = 1'b0;
                        cnt_next  = '0;
                        st_next   = ST_DATA;
                    end
                    else
                    begin
                        // escaped IAC is stored as 255, anything else is dropped
                        if (in_byte == tiof_pkg::B_IAC && msdp_reg &&
                            cnt_reg < CNT_W'(PAYLOAD_MAX))
                        begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        st_next = ST_SBDATA;
                    end
                end
                default:
                begin
                    st_next = ST_DATA;
                end
            endcase
        end
    end

    // Replay sequencer: one RAM read per cycle unless stalled; pushed from registered rdata
    assign can_issue = rep_active_reg && (rep_cnt_reg != rep_len_reg) &&
                       (!pend_reg || buf_ready);

    always_comb
    begin
        rep_active_next = rep_active_reg;
        rep_len_next    = rep_len_reg;
        rep_cnt_next    = rep_cnt_reg;
        pend_next       = pend_reg;
        pend_last_next  = pend_last_reg;

        if (rep_start)
        begin
            rep_active_next = 1'b1;
            rep_len_next    = cnt_reg;
            rep_cnt_next    = '0;
            pend_next       = 1'b0;
        end
        else
        begin
            if (pend_reg && buf_ready)
            begin
                pend_next = 1'b0;
                if (pend_last_reg)
                begin
                    rep_active_next = 1'b0;
                end
            end
            if (can_issue)
            begin
                pend_next      = 1'b1;
                pend_last_next = (rep_cnt_reg + CNT_W'(1) == rep_len_reg);
                rep_cnt_next   = rep_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_DATA;
            neg_act_reg    <= 1'b0;
            neg_off_reg    <= 1'b0;
            msdp_reg       <= 1'b0;
            cnt_reg        <= '0;
            rep_active_reg <= 1'b0;
            rep_len_reg    <= '0;
            rep_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            neg_act_reg    <= neg_act_next;
            neg_off_reg    <= neg_off_next;
            msdp_reg       <= msdp_next;
            cnt_reg        <= cnt_next;
            rep_active_reg <= rep_active_next;
            rep_len_reg    <= rep_len_next;
            rep_cnt_reg    <= rep_cnt_next;
            pend_reg       <= pend_next;
            pend_last_reg  <= pend_last_next;
        end
    end

    tiof_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_MAX),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (in_byte),
        .re    (can_issue),
        .raddr (rep_cnt_reg[AW-1:0]),
        .rdata (rd_data)
    );

    always_comb
    begin
        res_r.kind   = tiof_pkg::KIND_PAYLOAD;
        res_r.value  = rd_data;
        res_r.length = rep_len_reg;
        res_r.last   = pend_last_reg;
    end

    // input is stalled during replay, so the two sources never push together
    assign up_data = pend_reg ? res_r : res_p;

    tiof_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (push_p || pend_reg),
        .up_data   (up_data),
        .up_ready  (buf_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign out_value      = out_data.value;
    assign payload_length = out_data.length;
    assign last           = out_data.last;

endmodule

`default_nettype wire

// ===== rtl/tiof_checker.sv =====
// Port-level checker for the telnet IAC option filter, bound to the top level.
`default_nettype none
`include "telnet_iac_option_filter_macros.svh"

module tiof_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [2:0]                 kind,
    input wire logic [7:0]                 out_value,
    input wire logic [tiof_pkg::CNT_W-1:0] payload_length,
    input wire logic                       last
);

    logic                        is_event;
    logic                        is_payload;
    logic [tiof_pkg::CNT_W+11:0] out_bits;

    assign is_event = (kind == tiof_pkg::KIND_COMP_ON) ||
                      (kind == tiof_pkg::KIND_COMP_OFF) ||
                      (kind == tiof_pkg::KIND_MSDP_ON) ||
                      (kind == tiof_pkg::KIND_MSDP_OFF) ||
                      (kind == tiof_pkg::KIND_EMPTY);
    assign is_payload = (kind == tiof_pkg::KIND_PAYLOAD);
    assign out_bits   = {kind, out_value, payload_length, last};

    `TIOF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `TIOF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_bits))
    `TIOF_ASSERT_IMP(a_len_only_payload, clk, rst_n, out_valid && !is_payload, payload_length == '0)
    `TIOF_ASSERT_IMP(a_event_single, clk, rst_n, out_valid && is_event, out_value == '0 && last)
    `TIOF_ASSERT_IMP(a_payload_len, clk, rst_n, out_valid && is_payload, payload_length != '0)

endmodule

bind telnet_iac_option_filter tiof_checker u_tiof_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the telnet IAC option filter with a scoreboard class.
`timescale 1ns / 1ps

module testbench;

    localparam int PAYLOAD_MAX = 64;
    localparam int CNT_W = tiof_pkg::CNT_W;
    localparam int RANDOM_ITEMS = 290;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [2:0] {
        P_DATA,
        P_IAC,
        P_NEG,
        P_SBOPT,
        P_SBDATA,
        P_SBIAC
    } parse_t;

    class iac_scoreboard;
        tiof_pkg::res_t filtered_q[$];
        parse_t         state;
        logic [7:0]     cmd;
        logic [7:0]     sub_opt;
        int             count;
        logic [7:0]     payload_mem[PAYLOAD_MAX];
        int             errors;

        function new();
            state = P_DATA;
            cmd = 8'd0;
            sub_opt = 8'd0;
            count = 0;
            errors = 0;
        endfunction

        function void push(logic [2:0] k, logic [7:0] v, logic [CNT_W-1:0] len, logic l);
            tiof_pkg::res_t r;
            r.kind = k;
            r.value = v;
            r.length = len;
            r.last = l;
            filtered_q.push_back(r);
        endfunction

        function void store(logic [7:0] b);
            if (sub_opt == tiof_pkg::OPT_MSDP && count < PAYLOAD_MAX)
            begin
                payload_mem[count] = b;
                count++;
            end
        endfunction

        // Advance the parser by one accepted byte and queue what it yields.
        function void parse_byte(logic [7:0] b);
            int k;
            case (state)
                P_DATA:
                    if (b == tiof_pkg::B_IAC)
                        state = P_IAC;
                    else
                        push(tiof_pkg::KIND_DATA, b, '0, 1'b1);
                P_IAC:
                    if (b == tiof_pkg::B_IAC)
                    begin
                        push(tiof_pkg::KIND_DATA, tiof_pkg::B_IAC, '0, 1'b1);
                        state = P_DATA;
                    end
                    else if (b == tiof_pkg::B_DO || b == tiof_pkg::B_DONT ||
                             b == tiof_pkg::B_WILL || b == tiof_pkg::B_WONT)
                    begin
                        cmd = b;
                        state = P_NEG;
                    end
                    else if (b == tiof_pkg::B_SB)
                    begin
                        sub_opt = 8'd0;
                        count = 0;
                        state = P_SBOPT;
                    end
                    else
                    begin
                        state = P_DATA;
                    end
                P_NEG:
                begin
                    if (cmd == tiof_pkg::B_DO || cmd == tiof_pkg::B_DONT)
                    begin
                        if (b == tiof_pkg::OPT_COMPRESS2)
                            push((cmd == tiof_pkg::B_DONT) ? tiof_pkg::KIND_COMP_OFF
                                                           : tiof_pkg::KIND_COMP_ON,
                                 8'd0, '0, 1'b1);
                        else if (b == tiof_pkg::OPT_MSDP)
                            push((cmd == tiof_pkg::B_DONT) ? tiof_pkg::KIND_MSDP_OFF
                                                           : tiof_pkg::KIND_MSDP_ON,
                                 8'd0, '0, 1'b1);
                    end
                    cmd = 8'd0;
                    state = P_DATA;
                end
                P_SBOPT:
                begin
                    sub_opt = b;
                    count = 0;
                    state = P_SBDATA;
                end
                P_SBDATA:
                    if (b == tiof_pkg::B_IAC)
                        state = P_SBIAC;
                    else
                        store(b);
                P_SBIAC:
                    if (b == tiof_pkg::B_SE)
                    begin
                        if (sub_opt == tiof_pkg::OPT_MSDP)
                        begin
                            if (count == 0)
                                push(tiof_pkg::KIND_EMPTY, 8'd0, '0, 1'b1);
                            else
                                for (k = 0; k < count; k++)
                                    push(tiof_pkg::KIND_PAYLOAD, payload_mem[k],
                                         CNT_W'(count), k + 1 == count);
                        end
                        sub_opt = 8'd0;
                        count = 0;
                        state = P_DATA;
                    end
                    else
                    begin
                        if (b == tiof_pkg::B_IAC)
                            store(tiof_pkg::B_IAC);
                        state = P_SBDATA;
                    end
                default:
                    state = P_DATA;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_filtered(logic [2:0] k, logic [7:0] v, logic [CNT_W-1:0] len,
                                     logic l);
            tiof_pkg::res_t want;
            if (filtered_q.size() == 0)
            begin
                report($sformatf("unexpected item kind=%0d value=%0d length=%0d last=%0d",
                                 k, v, len, l));
                return;
            end
            want = filtered_q.pop_front();
            if (want.kind !== k || want.value !== v || want.length !== len || want.last !== l)
                report($sformatf({"expected kind=%0d value=%0d length=%0d last=%0d, ",
                                  "got kind=%0d value=%0d length=%0d last=%0d"},
                                 want.kind, want.value, want.length, want.last,
                                 k, v, len, l));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_byte = 8'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2:0]             kind;
    logic [7:0]             out_value;
    logic [CNT_W-1:0]       payload_length;
    logic                   last;

    logic                   hold_off = 1'b0;
    int                     in_accepted = 0;
    int                     next_idx = 0;
    int                     cycle_count = 0;
    logic [7:0]             stim[$];
    iac_scoreboard          sb = new();

    // No idling on either side for a stretch of the stream.
    wire calm = (in_accepted >= 200 && in_accepted < 280);

    telnet_iac_option_filter #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .out_value(out_value),
        .payload_length(payload_length),
        .last(last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(0, 254));
    endfunction

    task automatic add_neg(logic [7:0] c, logic [7:0] opt);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(c);
        stim.push_back(opt);
    endtask

    // Subnegotiation of n payload bytes or dropped IAC pairs; a few left unterminated.
    task automatic add_subneg(logic [7:0] opt, int n, bit close);
        int i;
        int r;
        logic [7:0] b;
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_SB);
        stim.push_back(opt);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 10)
            begin
                stim.push_back(tiof_pkg::B_IAC);
                stim.push_back(tiof_pkg::B_IAC);
            end
            else if (r < 15)
            begin
                b = plain_byte();
                if (b == tiof_pkg::B_SE)
                    b = 8'd0;
                stim.push_back(tiof_pkg::B_IAC);
                stim.push_back(b);
            end
            else
            begin
                stim.push_back(plain_byte());
            end
        end
        if (close)
        begin
            stim.push_back(tiof_pkg::B_IAC);
            stim.push_back(tiof_pkg::B_SE);
        end
    endtask

    task automatic build_stimulus();
        int base;
        int r;
        int i;
        logic [7:0] c;
        logic [7:0] opt;
        // directed: data extremes, escaped IAC, every negotiation event
        stim.push_back(8'd0);
        stim.push_back(8'd254);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_IAC);
        add_neg(tiof_pkg::B_DO, tiof_pkg::OPT_COMPRESS2);
        add_neg(tiof_pkg::B_DONT, tiof_pkg::OPT_COMPRESS2);
        add_neg(tiof_pkg::B_DO, tiof_pkg::OPT_MSDP);
        add_neg(tiof_pkg::B_DONT, tiof_pkg::OPT_MSDP);
        add_neg(tiof_pkg::B_WILL, tiof_pkg::OPT_COMPRESS2);
        // unknown command after IAC
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(8'd241);
        // payload with escaped IAC and a stray byte after IAC
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_SB);
        stim.push_back(tiof_pkg::OPT_MSDP);
        stim.push_back(8'h41);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(8'h01);
        stim.push_back(tiof_pkg::B_IAC);
        stim.push_back(tiof_pkg::B_SE);
        // empty MSDP payload, then SE for another option
        add_subneg(tiof_pkg::OPT_MSDP, 0, 1'b1);
        add_subneg(tiof_pkg::OPT_COMPRESS2, 0, 1'b1);

        base = stim.size();
        // long payload first, meant to overflow the buffer and hit the full-buffer path
        add_subneg(tiof_pkg::OPT_MSDP, 70, 1'b1);
        while (stim.size() < base + RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                stim.push_back(plain_byte());
            end
            else if (r < 45)
            begin
                stim.push_back(tiof_pkg::B_IAC);
                stim.push_back(tiof_pkg::B_IAC);
            end
            else if (r < 65)
            begin
                case ($urandom_range(3))
                    0: c = tiof_pkg::B_DO;
                    1: c = tiof_pkg::B_DONT;
                    2: c = tiof_pkg::B_WILL;
                    default: c = tiof_pkg::B_WONT;
                endcase
                r = $urandom_range(9);
                opt = (r < 4) ? tiof_pkg::OPT_COMPRESS2 :
                      (r < 8) ? tiof_pkg::OPT_MSDP : 8'($urandom_range(255));
                add_neg(c, opt);
            end
            else if (r < 85)
            begin
                opt = ($urandom_range(9) < 8) ? tiof_pkg::OPT_MSDP : 8'($urandom_range(255));
                if ($urandom_range(11) == 0)
                    add_subneg(opt, $urandom_range(60, 70), $urandom_range(9) != 0);
                else
                    add_subneg(opt, $urandom_range(6), $urandom_range(9) != 0);
            end
            else if (r < 92)
            begin
                stim.push_back(tiof_pkg::B_IAC);
                stim.push_back(8'($urandom_range(0, 249)));
            end
            else
            begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    stim.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (next_idx < stim.size() && (calm || $urandom_range(99) >= 10))
            begin
                in_valid <= 1'b1;
                in_byte <= stim[next_idx];
                next_idx <= next_idx + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (!calm && $urandom_range(99) < 10)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        while (in_accepted < 80)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitors
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.parse_byte(in_byte);
                in_accepted <= in_accepted + 1;
            end
            if (out_valid && !out_stall)
                sb.check_filtered(kind, out_value, payload_length, last);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        build_stimulus();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (in_accepted < stim.size())
            @(posedge clk);
        while (sb.filtered_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.filtered_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tiof_pkg.sv
rtl/tiof_ram.sv
rtl/tiof_outbuf.sv
rtl/telnet_iac_option_filter.sv
rtl/tiof_checker.sv
dv/testbench.sv
